@@ design/mtus_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtus_pkg
// Shared types and constants of the MT19937 uniform sampler.
// ----------------------------------------------------------------------------
package mtus_pkg;

  localparam int unsigned TW_N  = 624;
  localparam int unsigned TW_M  = 397;
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned PREC_W = 6;
  localparam int unsigned RAW_W  = 53;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [31:0]       word_t;

  // register indexes of the configuration port
  localparam logic [2:0] REG_SEED  = 3'd0;
  localparam logic [2:0] REG_SKIP  = 3'd1;
  localparam logic [2:0] REG_PREC  = 3'd2;
  localparam logic [2:0] REG_LOW   = 3'd3;
  localparam logic [2:0] REG_HIGH  = 3'd4;

  // table access: one write, one read
  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } mem_req_t;

  // scaling job handed to the multiply unit
  typedef struct packed {
    logic              start;
    logic [RAW_W-1:0]  v;
    logic [63:0]       span;
    logic [63:0]       low;
    logic [PREC_W-1:0] prec;
  } scale_req_t;

endpackage

@@ design/mtus_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtus_table
// Generator state table: 624 words, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module mtus_table (
  input  logic              clk,
  input  mtus_pkg::mem_req_t req,
  output mtus_pkg::word_t    rdata
);
  import mtus_pkg::*;

  word_t mem [TW_N];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ design/mtus_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtus_scale
// Computes low + floor(v * span / 2^prec) with four 32x32 partial products.
// ----------------------------------------------------------------------------
module mtus_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  mtus_pkg::scale_req_t req,
  output logic                 done,
  output logic [63:0]          sample
);
  import mtus_pkg::*;

  localparam int unsigned ACC_W = RAW_W + 64;

  typedef enum logic [3:0] {
    SC_IDLE  = 4'b0001,
    SC_MUL   = 4'b0010,
    SC_SHIFT = 4'b0100,
    SC_ADD   = 4'b1000
  } sc_state_t;

  sc_state_t         state;
  logic [RAW_W-1:0]  a;
  logic [63:0]       b;
  logic [63:0]       low;
  logic [PREC_W-1:0] prec;
  logic [2:0]        cnt;
  logic [63:0]       prod;
  logic [ACC_W-1:0]  acc;
  logic [63:0]       quo;
  logic [31:0]       pa;
  logic [31:0]       pb;
  logic [ACC_W-1:0]  addend;

  // cnt selects the partial product: a0b0, a0b1, a1b0, a1b1
  assign pa = cnt[1] ? {11'b0, a[RAW_W-1:32]} : a[31:0];
  assign pb = cnt[0] ? b[63:32] : b[31:0];

  always_comb begin
    addend = {{(ACC_W-64){1'b0}}, prod};
    case (cnt)
      3'd2, 3'd3: addend = addend << 32;
      3'd4:       addend = addend << 64;
      default:    addend = addend;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        SC_IDLE: begin
          if (req.start) begin
            a     <= req.v;
            b     <= req.span;
            low   <= req.low;
            prec  <= req.prec;
            acc   <= '0;
            cnt   <= '0;
            state <= SC_MUL;
          end
        end
        SC_MUL: begin
          if (cnt != 3'd4) begin
            prod <= pa * pb;
          end
          if (cnt != 3'd0) begin
            acc <= acc + addend;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= SC_SHIFT;
          end
        end
        SC_SHIFT: begin
          quo   <= 64'(acc >> prec);
          state <= SC_ADD;
        end
        SC_ADD: begin
          sample <= low + quo;
          done   <= 1'b1;
          state  <= SC_IDLE;
        end
        default: state <= SC_IDLE;
      endcase
    end
  end

endmodule

@@ design/mt19937_uniform_sampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_uniform_sampler
// Uniform sampler on a 32-bit MT19937 generator, signed Q32.32 results.
// ----------------------------------------------------------------------------
//
//  channel   direction  word / fields
//  s_axis    in         tdata[0] restart
//  m_axis    out        tdata[63:0] sample, tdata[116:64] raw_bits
//  cfg       in         cfg_index register, cfg_data value (always ready)
//
// A sample runs from one accept to the next through one generator word for
// precision up to 32 and two above (ST_WORD, ST_WCAP on the table read port),
// the hand-off to the 32x32 multiply unit (start, five partial-product steps,
// shift, add, done), the output register load in ST_OUT and idle. Every 624
// words a table regeneration runs ST_RG0, then ST_RGA, ST_RGB and ST_RGC per
// entry (three table accesses: two reads on the single read port, one write).
// Seeding writes one entry a cycle; a skip moves up to one table of words per
// cycle and regenerates whenever the table runs out. After reset the first
// request seeds. A stalled result waits in the output register; the next
// request is taken meanwhile and stalls only at its own delivery.
// ----------------------------------------------------------------------------
module mt19937_uniform_sampler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [0] restart
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // [63:0] sample, [116:64] raw_bits
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import mtus_pkg::*;

  localparam word_t SEED_MULT = 32'd1812433253;
  localparam word_t MAG       = 32'h9908B0DF;
  localparam addr_t LAST      = addr_t'(TW_N - 1);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_SEED  = 11'b00000000010,
    ST_SKIP  = 11'b00000000100,
    ST_RG0   = 11'b00000001000,
    ST_RGA   = 11'b00000010000,
    ST_RGB   = 11'b00000100000,
    ST_RGC   = 11'b00001000000,
    ST_WORD  = 11'b00010000000,
    ST_WCAP  = 11'b00100000000,
    ST_SCALE = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  // configuration registers
  logic [31:0]       seed_value;
  logic [31:0]       skip_count;
  logic [PREC_W-1:0] precision;
  logic [63:0]       low_bound;
  logic [63:0]       high_bound;

  state_t            state;
  logic              seeded;
  logic              rg_to_word;   // return from regeneration to word fetch
  logic              second;       // fetching the second word of a sample
  addr_t             pos;
  addr_t             idx;
  logic [31:0]       skip_left;
  word_t             prev;
  word_t             cur;
  word_t             nxt;
  word_t             hi_word;
  logic [RAW_W-1:0]  v;

  mem_req_t          mreq;
  word_t             rdata;
  scale_req_t        sreq;
  logic              sc_done;
  logic [63:0]       sc_sample;

  logic [PREC_W-1:0] p_eff;
  logic [63:0]       span;
  word_t             seed_x;
  word_t             seed_val;
  word_t             rg_y;
  word_t             rg_x;
  word_t             tw_y;
  addr_t             idx_p1;
  logic [ADDR_W:0]   idx_m_sum;
  addr_t             idx_m;
  addr_t             room;
  logic [63:0]       v_full;
  logic [RAW_W-1:0]  v_mask;
  logic              out_free;

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= 32'd5489;
      skip_count <= 32'd0;
      precision  <= PREC_W'(32);
      low_bound  <= 64'd0;
      high_bound <= 64'h0000_0001_0000_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEED: seed_value <= cfg_data[31:0];
        REG_SKIP: skip_count <= cfg_data[31:0];
        REG_PREC: precision  <= cfg_data[PREC_W-1:0];
        REG_LOW:  low_bound  <= cfg_data;
        REG_HIGH: high_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp precision to 1..53 and form the span, zero when bounds are reversed
  always_comb begin
    p_eff = precision;
    if (precision == '0) begin
      p_eff = PREC_W'(1);
    end else if (precision > PREC_W'(RAW_W)) begin
      p_eff = PREC_W'(RAW_W);
    end
    span = ($signed(high_bound) >= $signed(low_bound)) ? (high_bound - low_bound) : 64'd0;
  end

  always_comb begin
    seed_x    = prev ^ (prev >> 30);
    seed_val  = (idx == '0) ? seed_value : (seed_x * SEED_MULT) + word_t'(idx);
    idx_p1    = (idx == LAST) ? '0 : idx + addr_t'(1);
    idx_m_sum = {1'b0, idx} + (ADDR_W+1)'(TW_M);
    idx_m     = (idx_m_sum >= (ADDR_W+1)'(TW_N)) ? addr_t'(idx_m_sum - (ADDR_W+1)'(TW_N))
                                                 : idx_m_sum[ADDR_W-1:0];
    rg_y      = {cur[31], nxt[30:0]};
    rg_x      = rdata ^ (rg_y >> 1) ^ (rg_y[0] ? MAG : 32'd0);
    room      = addr_t'(TW_N) - pos;
    if ({22'b0, room} > skip_left) begin
      room = skip_left[ADDR_W-1:0];
    end
    tw_y   = temper(rdata);
    v_full = second ? {hi_word, tw_y} : {32'b0, tw_y};
    v_mask = v_full[RAW_W-1:0] & ((RAW_W'(1) << p_eff) - RAW_W'(1));
  end

  // table port: seeding writes, regeneration reads and writes, fetches read
  always_comb begin
    mreq.we    = 1'b0;
    mreq.waddr = idx;
    mreq.wdata = seed_val;
    mreq.raddr = pos;
    unique case (state)
      ST_SEED: mreq.we = 1'b1;
      ST_RG0:  mreq.raddr = '0;
      ST_RGA:  mreq.raddr = idx_p1;
      ST_RGB:  mreq.raddr = idx_m;
      ST_RGC: begin
        mreq.we    = 1'b1;
        mreq.wdata = rg_x;
      end
      default: mreq.raddr = pos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      seeded     <= 1'b0;
      pos        <= '0;
      idx        <= '0;
      second     <= 1'b0;
      rg_to_word <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            second <= 1'b0;
            if (s_axis_tdata[0] || !seeded) begin
              idx   <= '0;
              state <= ST_SEED;
            end else begin
              state <= ST_WORD;
            end
          end
        end
        ST_SEED: begin
          prev <= seed_val;
          idx  <= idx + addr_t'(1);
          if (idx == LAST) begin
            pos       <= addr_t'(TW_N);
            skip_left <= skip_count;
            seeded    <= 1'b1;
            state     <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip_left == 32'd0) begin
            state <= ST_WORD;
          end else if (pos >= addr_t'(TW_N)) begin
            rg_to_word <= 1'b0;
            idx        <= '0;
            state      <= ST_RG0;
          end else begin
            pos       <= pos + room;
            skip_left <= skip_left - {22'b0, room};
          end
        end
        ST_RG0: state <= ST_RGA;
        ST_RGA: begin
          if (idx == '0) begin
            cur <= rdata;
          end
          state <= ST_RGB;
        end
        ST_RGB: begin
          nxt   <= rdata;
          state <= ST_RGC;
        end
        ST_RGC: begin
          cur <= nxt;
          idx <= idx_p1;
          if (idx == LAST) begin
            pos   <= '0;
            state <= rg_to_word ? ST_WORD : ST_SKIP;
          end else begin
            state <= ST_RGA;
          end
        end
        ST_WORD: begin
          if (pos >= addr_t'(TW_N)) begin
            rg_to_word <= 1'b1;
            idx        <= '0;
            state      <= ST_RG0;
          end else begin
            state <= ST_WCAP;
          end
        end
        ST_WCAP: begin
          pos <= pos + addr_t'(1);
          if (!second && (p_eff > PREC_W'(32))) begin
            hi_word <= tw_y;
            second  <= 1'b1;
            state   <= ST_WORD;
          end else begin
            v     <= v_mask;
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (sc_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // start the multiply unit together with the new v, both registered in ST_WCAP
  logic scale_go;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_go <= 1'b0;
    end else begin
      scale_go <= (state == ST_WCAP) && !(!second && (p_eff > PREC_W'(32)));
    end
  end

  always_comb begin
    sreq.start = scale_go;
    sreq.v     = v;
    sreq.span  = span;
    sreq.low   = low_bound;
    sreq.prec  = p_eff;
  end

  // output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      m_axis_tdata <= {3'b0, v, sc_sample};
    end
  end

  mtus_table u_table (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  mtus_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .req    (sreq),
    .done   (sc_done),
    .sample (sc_sample)
  );

  a_regen_wraps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RGC && idx == LAST) |=> (pos == '0))
    else $error("regeneration did not rewind the table position");

  a_fetch_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WCAP) |-> (pos < addr_t'(TW_N)))
    else $error("word fetched beyond the table");

  a_skip_seeded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP) |-> seeded)
    else $error("skip running on an unseeded table");

  a_done_in_scale: assert property (@(posedge clk) disable iff (rst)
    sc_done |-> (state == ST_SCALE))
    else $error("scale result arrived outside the scale phase");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MT19937 uniform sampler. A class-based
// scoreboard keeps its own twister and scaling model, predicts every sample
// from the accepted requests and compares each delivered word field by field.
// Requests come in bursts with gaps, the result side stalls on its own pattern
// and the configuration is changed between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mtus_pkg::*;

  localparam int IDLE_LIMIT = 60000;   // idle cycles before the watchdog fires
  localparam int DRAIN_WAIT = 40;      // settle cycles after the last result
  localparam int LONG_HOLD  = 400;     // long result-side hold-off

  // Model of the generator plus the Q32.32 scaling, and the queue of
  // predicted samples still owed by the block.
  class sample_scoreboard;
    logic [31:0]  seed_reg, skip_reg;
    logic [5:0]   prec_reg;
    logic [63:0]  low_reg, high_reg;
    logic [31:0]  tab [TW_N];
    int unsigned  pos;
    bit           seeded;
    logic [63:0]  owed_sample[$];
    logic [52:0]  owed_raw[$];
    int           errors;

    function new();
      seed_reg = 32'd5489; skip_reg = 0; prec_reg = 6'd32;
      low_reg = 0; high_reg = 64'h1_0000_0000;
      pos = 0; seeded = 0; errors = 0;
      foreach (tab[i]) tab[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_SEED: seed_reg = val[31:0];
        REG_SKIP: skip_reg = val[31:0];
        REG_PREC: prec_reg = val[5:0];
        REG_LOW:  low_reg  = val;
        REG_HIGH: high_reg = val;
        default: ;
      endcase
    endfunction

    function void reseed();
      logic [31:0] p;
      tab[0] = seed_reg;
      for (int i = 1; i < TW_N; i++) begin
        p = tab[i-1];
        p = p ^ (p >> 30);
        tab[i] = p * 32'd1812433253 + i;
      end
      pos = TW_N;
    endfunction

    function void regen();
      logic [31:0] y, x;
      for (int i = 0; i < TW_N; i++) begin
        y = (tab[i] & 32'h8000_0000) | (tab[(i+1) % TW_N] & 32'h7FFF_FFFF);
        x = tab[(i + TW_M) % TW_N] ^ (y >> 1);
        if (y[0]) x = x ^ 32'h9908_B0DF;
        tab[i] = x;
      end
      pos = 0;
    endfunction

    function logic [31:0] next_word();
      logic [31:0] y;
      if (pos >= TW_N) regen();
      y = tab[pos];
      pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
    endfunction

    function void discard(longint unsigned k);
      longint unsigned room;
      while (k > 0) begin
        if (pos >= TW_N) regen();
        room = TW_N - pos;
        if (room > k) room = k;
        pos += 32'(room);
        k -= room;
      end
    endfunction

    // Predict the word caused by one accepted request.
    function void note_request(bit restart);
      int unsigned  p;
      logic [63:0]  v, mask, span;
      logic [127:0] prod;
      p = {26'd0, prec_reg};
      if (p < 1) p = 1;
      if (p > 53) p = 53;
      if (restart || !seeded) begin
        reseed();
        discard({32'd0, skip_reg});
        seeded = 1;
      end
      v = {32'd0, next_word()};
      if (p > 32) v = (v << 32) | {32'd0, next_word()};
      mask = (64'd1 << p) - 64'd1;
      v = v & mask;
      // reversed bounds give a zero span
      span = ($signed(high_reg) >= $signed(low_reg)) ? high_reg - low_reg : 64'd0;
      prod = ({64'd0, v} * {64'd0, span}) >> p;
      owed_sample.push_back(low_reg + prod[63:0]);
      owed_raw.push_back(v[52:0]);
    endfunction

    function void check_result(logic [63:0] sample, logic [52:0] raw);
      logic [63:0] es;
      logic [52:0] er;
      if (owed_sample.size() == 0) begin
        $display("%0t: unexpected word sample=%h raw=%h", $time, sample, raw);
        errors++;
        return;
      end
      es = owed_sample.pop_front();
      er = owed_raw.pop_front();
      if (sample !== es) begin
        $display("%0t: sample expected %h actual %h", $time, es, sample);
        errors++;
      end
      if (raw !== er) begin
        $display("%0t: raw_bits expected %h actual %h", $time, er, raw);
        errors++;
      end
    endfunction

    function int pending();
      return owed_sample.size();
    endfunction
  endclass

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [119:0] m_axis_tdata;
  logic         cfg_valid, cfg_ready;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  sample_scoreboard sb;
  int hold_token;     // bumped by the stimulus to request a long hold-off
  int idle_cycles;

  mt19937_uniform_sampler dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Result side: stall on a pattern of its own, check every accepted word.
  int rx_cnt, hold_left, hold_seen;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[63:0], m_axis_tdata[116:64]);
    rx_cnt <= rx_cnt + 1;
    if (hold_seen != hold_token) begin
      // start a long hold-off; the sender keeps pushing meanwhile
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (((rx_cnt >> 7) & 3) == 0) begin
      m_axis_tready <= 1'b1;     // stretch with no stalls
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("mt19937_uniform_sampler: mismatch");
      $finish;
    end
  end

  // Hold valid high; the caller drops it after the last write of a batch.
  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic cfg_idle();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] seed, logic [31:0] skip, logic [5:0] prec,
                           logic [63:0] lo, logic [63:0] hi);
    cfg_write(REG_SEED, {32'd0, seed});
    cfg_write(REG_SKIP, {32'd0, skip});
    cfg_write(REG_PREC, {58'd0, prec});
    cfg_write(REG_LOW, lo);
    cfg_write(REG_HIGH, hi);
    cfg_idle();
  endtask

  // Send n requests in bursts; restart_pct is the chance of a reseed per word.
  task automatic send_requests(int n, int restart_pct, bit first_restart);
    int burst, gap;
    bit rs;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      rs = (i == 0 && first_restart) || ($urandom_range(0, 99) < restart_pct);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {7'd0, rs};
      do @(posedge clk); while (!s_axis_tready);
      sb.note_request(rs);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Pause until every predicted word has arrived, then let the block settle.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_phase(int n, int restart_pct, bit first_restart);
    send_requests(n, restart_pct, first_restart);
    drain();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] a, b;
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    hold_token = 0; hold_seen = 0; hold_left = 0; rx_cnt = 0; idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, first request seeds without restart.
    run_phase(3, 0, 0);
    run_phase(2, 100, 1);
    // precision extremes, out-of-range precision clamps at both ends
    write_all(32'd0, 32'd0, 6'd1, 64'd0, 64'h1_0000_0000);
    run_phase(2, 0, 1);
    write_all(32'hFFFF_FFFF, 32'd5, 6'd53, 64'd0, 64'h1_0000_0000);
    run_phase(2, 0, 1);
    write_all(32'd12345, 32'd1, 6'd0, 64'hFFFF_FFFF_0000_0000, 64'h1_0000_0000);
    run_phase(2, 0, 1);
    write_all(32'd777, 32'd623, 6'd63, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    run_phase(2, 0, 1);
    // reversed bounds: sample stays at low bound
    write_all(32'd42, 32'd624, 6'd33, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    run_phase(2, 0, 1);
    // skip crossing a regeneration, then the widest skip written and replaced
    write_all(32'd9, 32'd1300, 6'd32, 64'd5, 64'd5);
    cfg_write(REG_SKIP, 64'hFFFF_FFFF);
    cfg_write(REG_SKIP, 64'd625);
    cfg_idle();
    run_phase(3, 50, 1);

    // Random phases; one of them includes a long result-side hold-off.
    for (int ph = 0; ph < 16; ph++) begin
      a = rand64();
      b = rand64();
      if ($urandom_range(0, 3) != 0 && $signed(a) > $signed(b)) begin
        a = a ^ b; b = a ^ b; a = a ^ b;
      end
      if ($urandom_range(0, 3) == 0) begin
        a = {{32{a[63]}}, a[31:0]} >>> 8;
        b = a + {32'd0, $urandom_range(0, 1 << 20)};
      end
      write_all($urandom(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1500)
                                                        : $urandom_range(0, 40),
                6'($urandom_range(0, 63)), a, b);
      if (ph == 5) hold_token = hold_token + 1;
      run_phase(30, 6, 1'($urandom_range(0, 1)));
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("mt19937_uniform_sampler: match");
    end else begin
      $display("mt19937_uniform_sampler: mismatch");
    end
    $finish;
  end
endmodule

@@ mt19937_uniform_sampler.f @@
design/mtus_pkg.sv
design/mtus_table.sv
design/mtus_scale.sv
design/mt19937_uniform_sampler.sv
sim/tb_top.sv
